>>> src/rvalu_pkg.sv
// rvalu_pkg: operation codes, pipeline word type and depth constants
// for the pipelined rv32im integer alu; no dependencies
`default_nettype none

package rvalu_pkg;

    localparam int unsigned XLEN      = 32;
    localparam int unsigned FUNC_W    = 5;
    localparam int unsigned TAG_W     = 5;
    localparam int unsigned SHAMT_W   = 5;
    // prep register, one stage per quotient bit, output register
    localparam int unsigned NUM_STG   = XLEN + 2;
    // stage whose register holds the finished product
    localparam int unsigned MUL_STG   = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 5'd0,
        FN_SUB    = 5'd1,
        FN_AND    = 5'd2,
        FN_OR     = 5'd3,
        FN_XOR    = 5'd4,
        FN_SLL    = 5'd5,
        FN_SRL    = 5'd6,
        FN_SRA    = 5'd7,
        FN_SLT    = 5'd8,
        FN_SLTU   = 5'd9,
        FN_MUL    = 5'd10,
        FN_MULH   = 5'd11,
        FN_MULHSU = 5'd12,
        FN_MULHU  = 5'd13,
        FN_DIV    = 5'd14,
        FN_DIVU   = 5'd15,
        FN_REM    = 5'd16,
        FN_REMU   = 5'd17
    } t_func;

    // payload that travels down the pipeline with each word
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [TAG_W-1:0]  tag;
        logic [XLEN-1:0]   res;     // finished result when use_res is set
        logic [XLEN-1:0]   rem;     // partial remainder
        logic [XLEN-1:0]   quo;     // dividend shifting out, quotient in
        logic [XLEN-1:0]   dvs;     // divisor magnitude
        logic              neg_q;
        logic              neg_r;
        logic              use_res;
        logic              dz;
    } t_pipe;

    function automatic logic is_mul(input logic [FUNC_W-1:0] f);
        is_mul = (f == FN_MUL) || (f == FN_MULH) || (f == FN_MULHSU) || (f == FN_MULHU);
    endfunction

endpackage

`default_nettype wire

>>> src/rvalu_if.sv
// rvalu_in_if / rvalu_out_if: valid-ready channels for the alu words
// depends on rvalu_pkg for field widths
`default_nettype none

interface rvalu_in_if;
    logic                           valid;
    logic                           ready;
    logic [rvalu_pkg::FUNC_W-1:0]   func;
    logic [rvalu_pkg::XLEN-1:0]     operand_a;
    logic [rvalu_pkg::XLEN-1:0]     operand_b;
    logic [rvalu_pkg::TAG_W-1:0]    dest_reg;
    modport source (output valid, func, operand_a, operand_b, dest_reg, input ready);
    modport sink   (input valid, func, operand_a, operand_b, dest_reg, output ready);
endinterface

interface rvalu_out_if;
    logic                           valid;
    logic                           ready;
    logic [rvalu_pkg::XLEN-1:0]     result;
    logic [rvalu_pkg::TAG_W-1:0]    dest_tag;
    logic                           div_by_zero;
    modport source (output valid, result, dest_tag, div_by_zero, input ready);
    modport sink   (input valid, result, dest_tag, div_by_zero, output ready);
endinterface

`default_nettype wire

>>> src/rvalu_prep.sv
// rvalu_prep: decode, combinational alu ops and divider set-up
// depends on rvalu_pkg
`default_nettype none

module rvalu_prep (
    input  wire logic [rvalu_pkg::FUNC_W-1:0] i_func,
    input  wire logic [rvalu_pkg::XLEN-1:0]   i_a,
    input  wire logic [rvalu_pkg::XLEN-1:0]   i_b,
    input  wire logic [rvalu_pkg::TAG_W-1:0]  i_tag,
    output rvalu_pkg::t_pipe                  o_pipe
);

    logic [rvalu_pkg::SHAMT_W-1:0] w_sh;
    logic                          w_sg;
    logic                          w_na;
    logic                          w_nb;
    logic                          w_div;
    logic                          w_quo;
    logic                          w_b0;
    logic [rvalu_pkg::XLEN-1:0]    w_alu;

    assign w_sh  = i_b[rvalu_pkg::SHAMT_W-1:0];
    assign w_sg  = (i_func == rvalu_pkg::FN_DIV) || (i_func == rvalu_pkg::FN_REM);
    assign w_div = w_sg || (i_func == rvalu_pkg::FN_DIVU) || (i_func == rvalu_pkg::FN_REMU);
    assign w_quo = (i_func == rvalu_pkg::FN_DIV) || (i_func == rvalu_pkg::FN_DIVU);
    assign w_na  = w_sg & i_a[rvalu_pkg::XLEN-1];
    assign w_nb  = w_sg & i_b[rvalu_pkg::XLEN-1];
    assign w_b0  = (i_b == '0);

    // combinational alu operations
    always_comb begin
        case (i_func)
            rvalu_pkg::FN_ADD:  w_alu = i_a + i_b;
            rvalu_pkg::FN_SUB:  w_alu = i_a - i_b;
            rvalu_pkg::FN_AND:  w_alu = i_a & i_b;
            rvalu_pkg::FN_OR:   w_alu = i_a | i_b;
            rvalu_pkg::FN_XOR:  w_alu = i_a ^ i_b;
            rvalu_pkg::FN_SLL:  w_alu = i_a << w_sh;
            rvalu_pkg::FN_SRL:  w_alu = i_a >> w_sh;
            rvalu_pkg::FN_SRA:  w_alu = rvalu_pkg::XLEN'($signed(i_a) >>> w_sh);
            rvalu_pkg::FN_SLT:  w_alu = {{(rvalu_pkg::XLEN-1){1'b0}},
                                         ($signed(i_a) < $signed(i_b))};
            rvalu_pkg::FN_SLTU: w_alu = {{(rvalu_pkg::XLEN-1){1'b0}}, (i_a < i_b)};
            default:            w_alu = '0;
        endcase
    end

    // divider set-up: magnitudes, result signs, zero-divisor answer; alu result otherwise
    always_comb begin
        o_pipe.func    = i_func;
        o_pipe.tag     = i_tag;
        o_pipe.rem     = '0;
        o_pipe.quo     = w_na ? (~i_a + 1'b1) : i_a;
        o_pipe.dvs     = w_nb ? (~i_b + 1'b1) : i_b;
        o_pipe.neg_q   = w_na ^ w_nb;
        o_pipe.neg_r   = w_na;
        o_pipe.dz      = w_div & w_b0;
        o_pipe.use_res = !w_div || w_b0;
        if (w_div) begin
            o_pipe.res = w_quo ? '1 : i_a;
        end else begin
            o_pipe.res = w_alu;
        end
    end

endmodule

`default_nettype wire

>>> src/rvalu_mul.sv
// rvalu_mul: three-stage 32x32 multiplier from 16x16 partial products
// depends on rvalu_pkg
`default_nettype none

module rvalu_mul (
    input  wire logic                         i_clk,
    input  wire logic [2:0]                   i_en,
    input  wire logic [rvalu_pkg::FUNC_W-1:0] i_func,
    input  wire logic [rvalu_pkg::XLEN-1:0]   i_a,
    input  wire logic [rvalu_pkg::XLEN-1:0]   i_b,
    output logic      [rvalu_pkg::XLEN-1:0]   o_res
);

    localparam int unsigned H = rvalu_pkg::XLEN / 2;

    logic [rvalu_pkg::XLEN-1:0]   r_ll, r_lh, r_hl, r_hh, r_corr1, r_corr2;
    logic                         r_hi1, r_hi2;
    logic [2*rvalu_pkg::XLEN-1:0] r_prod;
    logic [rvalu_pkg::XLEN-1:0]   n_corr;
    logic                         w_sa, w_sb;

    // sign corrections turn the unsigned high word into the signed one
    assign w_sa = ((i_func == rvalu_pkg::FN_MULH) || (i_func == rvalu_pkg::FN_MULHSU))
                  && i_a[rvalu_pkg::XLEN-1];
    assign w_sb = (i_func == rvalu_pkg::FN_MULH) && i_b[rvalu_pkg::XLEN-1];
    assign n_corr = (w_sa ? i_b : '0) + (w_sb ? i_a : '0);

    // partial products
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ll    <= i_a[H-1:0] * i_b[H-1:0];
            r_lh    <= i_a[H-1:0] * i_b[rvalu_pkg::XLEN-1:H];
            r_hl    <= i_a[rvalu_pkg::XLEN-1:H] * i_b[H-1:0];
            r_hh    <= i_a[rvalu_pkg::XLEN-1:H] * i_b[rvalu_pkg::XLEN-1:H];
            r_corr1 <= n_corr;
            r_hi1   <= (i_func != rvalu_pkg::FN_MUL);
        end
    end

    // sum of partial products
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_prod  <= {r_hh, r_ll}
                       + {{H{1'b0}}, r_lh, {H{1'b0}}}
                       + {{H{1'b0}}, r_hl, {H{1'b0}}};
            r_corr2 <= r_corr1;
            r_hi2   <= r_hi1;
        end
    end

    // word select and sign correction
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            o_res <= r_hi2 ? (r_prod[2*rvalu_pkg::XLEN-1:rvalu_pkg::XLEN] - r_corr2)
                           : r_prod[rvalu_pkg::XLEN-1:0];
        end
    end

endmodule

`default_nettype wire

>>> src/rvalu_div_step.sv
// rvalu_div_step: one restoring-division stage, one quotient bit per word
// depends on rvalu_pkg
`default_nettype none

module rvalu_div_step (
    input  wire logic      i_clk,
    input  wire logic      i_en,
    input  rvalu_pkg::t_pipe i_pipe,
    output rvalu_pkg::t_pipe o_pipe
);

    logic [rvalu_pkg::XLEN:0] w_trial;
    logic [rvalu_pkg::XLEN:0] w_diff;
    logic                     w_bit;
    rvalu_pkg::t_pipe         n_pipe;

    // shift in next dividend bit and try subtracting the divisor
    assign w_trial = {i_pipe.rem, i_pipe.quo[rvalu_pkg::XLEN-1]};
    assign w_diff  = w_trial - {1'b0, i_pipe.dvs};
    assign w_bit   = !w_diff[rvalu_pkg::XLEN];

    always_comb begin
        n_pipe     = i_pipe;
        n_pipe.rem = w_bit ? w_diff[rvalu_pkg::XLEN-1:0] : w_trial[rvalu_pkg::XLEN-1:0];
        n_pipe.quo = {i_pipe.quo[rvalu_pkg::XLEN-2:0], w_bit};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_pipe <= n_pipe;
        end
    end

endmodule

`default_nettype wire

>>> src/rv32im_integer_alu_top.sv
// rv32im_integer_alu_top: pipelined rv32im execute unit
// depends on rvalu_pkg, rvalu_if, rvalu_prep, rvalu_mul, rvalu_div_step
// every operation passes the prep stage, 32 divider bit stages and the output
// register; throughput: one word per cycle when not stalled, set by one
// quotient bit per stage. each stage advances when it or any later stage is
// empty. reset clears all stage valid bits; payload registers are not reset.
`default_nettype none

module rv32im_integer_alu_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rvalu_in_if.sink   i_in,
    rvalu_out_if.source o_out
);

    localparam int unsigned NS = rvalu_pkg::NUM_STG;

    logic [NS-1:0]              r_v;
    logic [NS-1:0]              w_en;
    rvalu_pkg::t_pipe           w_p   [NS-1];
    rvalu_pkg::t_pipe           w_pin [1:NS-2];
    rvalu_pkg::t_pipe           w_prep;
    rvalu_pkg::t_pipe           r_p0;
    rvalu_pkg::t_pipe           r_out;
    rvalu_pkg::t_pipe           n_out;
    rvalu_pkg::t_pipe           w_last;
    logic [rvalu_pkg::XLEN-1:0] r_a, r_b;
    logic [rvalu_pkg::XLEN-1:0] w_mul;
    logic [rvalu_pkg::XLEN-1:0] n_res;

    // stage k moves when output is taken or some stage from k on is empty
    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_en
            localparam logic [NS-1:0] LOW = NS'((64'd1 << k) - 64'd1);
            assign w_en[k] = o_out.ready || ((r_v | LOW) != '1);
        end
    endgenerate

    assign i_in.ready = w_en[0];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (w_en[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    // prep stage
    rvalu_prep u_prep (
        .i_func (i_in.func),
        .i_a    (i_in.operand_a),
        .i_b    (i_in.operand_b),
        .i_tag  (i_in.dest_reg),
        .o_pipe (w_prep)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_p0 <= w_prep;
            r_a  <= i_in.operand_a;
            r_b  <= i_in.operand_b;
        end
    end

    assign w_p[0] = r_p0;

    rvalu_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_en[rvalu_pkg::MUL_STG:1]),
        .i_func (w_p[0].func),
        .i_a    (r_a),
        .i_b    (r_b),
        .o_res  (w_mul)
    );

    // divider bit stages; product merged in after the multiplier
    generate
        for (k = 1; k < NS-1; k++) begin : g_div
            if (k == rvalu_pkg::MUL_STG + 1) begin : g_merge
                always_comb begin
                    w_pin[k] = w_p[k-1];
                    if (rvalu_pkg::is_mul(w_p[k-1].func)) begin
                        w_pin[k].res = w_mul;
                    end
                end
            end else begin : g_pass
                assign w_pin[k] = w_p[k-1];
            end
            rvalu_div_step u_step (
                .i_clk  (i_clk),
                .i_en   (w_en[k]),
                .i_pipe (w_pin[k]),
                .o_pipe (w_p[k])
            );
        end
    endgenerate

    // final sign fix-up and result select
    assign w_last = w_p[NS-2];
    always_comb begin
        if (w_last.use_res) begin
            n_res = w_last.res;
        end else if ((w_last.func == rvalu_pkg::FN_REM) || (w_last.func == rvalu_pkg::FN_REMU)) begin
            n_res = w_last.neg_r ? (~w_last.rem + 1'b1) : w_last.rem;
        end else begin
            n_res = w_last.neg_q ? (~w_last.quo + 1'b1) : w_last.quo;
        end
    end

    always_comb begin
        n_out     = w_last;
        n_out.res = n_res;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid       = r_v[NS-1];
    assign o_out.result      = r_out.res;
    assign o_out.dest_tag    = r_out.tag;
    assign o_out.div_by_zero = r_out.dz;

    // an empty output register always lets a new word in
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[NS-1] |-> i_in.ready)
        else $error("input stalled with empty output register");

    // zero-divisor flag only on division operations
    a_dz_div_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.div_by_zero) |->
            ((r_out.func == rvalu_pkg::FN_DIV) || (r_out.func == rvalu_pkg::FN_DIVU) ||
             (r_out.func == rvalu_pkg::FN_REM) || (r_out.func == rvalu_pkg::FN_REMU)))
        else $error("divide-by-zero flag on non-division word");

    // quotient of a zero divisor is all ones
    a_dz_quotient: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.div_by_zero &&
         ((r_out.func == rvalu_pkg::FN_DIV) || (r_out.func == rvalu_pkg::FN_DIVU)))
            |-> (o_out.result == '1))
        else $error("zero-divisor quotient not all ones");

endmodule

`default_nettype wire
